// ===== hdl/exchange_file_lexer_core_macros.svh =====
// Assertion macros for the exchange file lexer.
// Included by modules that check their own logic; expects clk_i and rst_ni in scope.
`ifndef EXCHANGE_FILE_LEXER_CORE_MACROS_SVH
`define EXCHANGE_FILE_LEXER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define EFL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("efl assertion failed");
`define EFL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("efl assertion failed");
`else
`define EFL_ASSERT(lbl, prop)
`define EFL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hdl/efl_pkg.sv =====
// Shared types and constants for the exchange file lexer.
// No dependencies; used by the token interface and every module of the block.
package efl_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned OUT_OFFSET_W    = 32;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic KIND_WORD     = 1'b0;
  localparam logic KIND_OPERATOR = 1'b1;

  typedef struct packed {
    logic                    emit_word;
    logic                    emit_op;
    logic [7:0]              op_byte;
    logic [OUT_OFFSET_W-1:0] word_start;
    logic [OUT_OFFSET_W-1:0] op_offset;
  } action_t;

  typedef struct packed {
    logic                    token_kind;
    logic [7:0]              operator_byte;
    logic [OUT_OFFSET_W-1:0] start_offset;
    logic                    last;
  } token_t;

endpackage

// ===== hdl/efl_if.sv =====
// Handshake channels of the exchange file lexer: input bytes and output tokens.
// Depends on efl_pkg for the offset width.
interface efl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;
  modport source (output valid, data_byte, stream_end, input ready);
  modport sink (input valid, data_byte, stream_end, output ready);
endinterface

interface efl_token_if;
  logic                             valid;
  logic                             ready;
  logic                             token_kind;
  logic [7:0]                       operator_byte;
  logic [efl_pkg::OUT_OFFSET_W-1:0] start_offset;
  logic                             last;
  modport source (output valid, token_kind, operator_byte, start_offset, last, input ready);
  modport sink (input valid, token_kind, operator_byte, start_offset, last, output ready);
endinterface

// ===== hdl/efl_front.sv =====
// Front end: accepts bytes, tracks word, string and comment state, emits actions.
// Depends on efl_pkg.
module efl_front #(
  parameter int unsigned OFFSET_BITS = efl_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             stream_end_i,
  input  logic             full_i,
  output logic             push_o,
  output efl_pkg::action_t action_o
);

  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic                   active_q, active_d;
  logic                   str_q, str_d;
  logic                   cmt_q, cmt_d;
  logic [7:0]             prev_q, prev_d;

  logic accept;
  logic is_space, is_delim, is_op;
  logic keep_str, keep_cmt;
  logic base_str, base_cmt;
  logic [7:0] base_prev;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;

  assign is_space = (data_byte_i == efl_pkg::CH_SPACE) || (data_byte_i == efl_pkg::CH_CR) ||
                    (data_byte_i == efl_pkg::CH_LF) || (data_byte_i == efl_pkg::CH_TAB);
  assign is_delim = (data_byte_i == efl_pkg::CH_LPAREN) || (data_byte_i == efl_pkg::CH_RPAREN) ||
                    (data_byte_i == efl_pkg::CH_EQUAL) || (data_byte_i == efl_pkg::CH_COMMA) ||
                    (data_byte_i == efl_pkg::CH_SEMI);
  assign is_op    = is_delim || (data_byte_i == efl_pkg::CH_DOLLAR) ||
                    (data_byte_i == efl_pkg::CH_STAR);

  // a fresh word starts from cleared flags
  assign base_str  = active_q ? str_q  : 1'b0;
  assign base_cmt  = active_q ? cmt_q  : 1'b0;
  assign base_prev = active_q ? prev_q : 8'h00;

  always_comb begin
    keep_str = base_str;
    keep_cmt = base_cmt;
    if (base_cmt && base_prev == efl_pkg::CH_STAR && data_byte_i == efl_pkg::CH_SLASH) begin
      keep_cmt = 1'b0;
    end else if (!base_str && !base_cmt && base_prev == efl_pkg::CH_SLASH &&
                 data_byte_i == efl_pkg::CH_STAR) begin
      keep_cmt = 1'b1;
    end else if (!base_cmt && data_byte_i == efl_pkg::CH_QUOTE) begin
      keep_str = !base_str;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    start_d  = start_q;
    active_d = active_q;
    str_d    = str_q;
    cmt_d    = cmt_q;
    prev_d   = prev_q;
    push_o   = 1'b0;
    action_o            = '0;
    action_o.op_byte    = data_byte_i;
    action_o.word_start = efl_pkg::OUT_OFFSET_W'(start_q);
    action_o.op_offset  = efl_pkg::OUT_OFFSET_W'(pos_q);
    if (accept) begin
      if (stream_end_i) begin
        push_o             = active_q;
        action_o.emit_word = 1'b1;
        pos_d    = '0;
        start_d  = '0;
        active_d = 1'b0;
        str_d    = 1'b0;
        cmt_d    = 1'b0;
        prev_d   = 8'h00;
      end else begin
        pos_d = pos_q + OFFSET_BITS'(1);
        if (!active_q) begin
          if (is_op) begin
            push_o           = 1'b1;
            action_o.emit_op = 1'b1;
          end else if (!is_space) begin
            active_d = 1'b1;
            start_d  = pos_q;
            str_d    = keep_str;
            cmt_d    = keep_cmt;
            prev_d   = data_byte_i;
          end
        end else if ((!str_q || cmt_q) && is_delim) begin
          push_o             = 1'b1;
          action_o.emit_word = 1'b1;
          action_o.emit_op   = 1'b1;
          start_d  = '0;
          active_d = 1'b0;
          str_d    = 1'b0;
          cmt_d    = 1'b0;
          prev_d   = 8'h00;
        end else if (!(!cmt_q && !str_q && is_space)) begin
          str_d  = keep_str;
          cmt_d  = keep_cmt;
          prev_d = data_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      start_q  <= '0;
      active_q <= 1'b0;
      str_q    <= 1'b0;
      cmt_q    <= 1'b0;
      prev_q   <= 8'h00;
    end else begin
      pos_q    <= pos_d;
      start_q  <= start_d;
      active_q <= active_d;
      str_q    <= str_d;
      cmt_q    <= cmt_d;
      prev_q   <= prev_d;
    end
  end

endmodule

// ===== hdl/efl_queue.sv =====
// Short action queue between the front and back ends.
// Depends on efl_pkg for the action type.
module efl_queue #(
  parameter int unsigned DEPTH = efl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  efl_pkg::action_t action_i,
  input  logic             pop_i,
  output efl_pkg::action_t head_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  efl_pkg::action_t slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= action_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/efl_back.sv =====
// Back end: expands queued actions into one or two tokens through an output register.
// Depends on efl_pkg and the assertion macro header.
`include "exchange_file_lexer_core_macros.svh"
module efl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  efl_pkg::action_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output efl_pkg::token_t  token_o
);

  logic            valid_q;
  logic            word_sent_q, word_sent_d;
  efl_pkg::token_t token_q, token_d;
  logic            load;

  assign load    = !empty_i && (!valid_q || ready_i);
  assign valid_o = valid_q;
  assign token_o = token_q;

  always_comb begin
    pop_o       = 1'b0;
    word_sent_d = word_sent_q;
    token_d     = token_q;
    if (load) begin
      if (head_i.emit_word && !word_sent_q) begin
        token_d.token_kind    = efl_pkg::KIND_WORD;
        token_d.operator_byte = 8'h00;
        token_d.start_offset  = head_i.word_start;
        token_d.last          = !head_i.emit_op;
        word_sent_d           = head_i.emit_op;
        pop_o                 = !head_i.emit_op;
      end else begin
        token_d.token_kind    = efl_pkg::KIND_OPERATOR;
        token_d.operator_byte = head_i.op_byte;
        token_d.start_offset  = head_i.op_offset;
        token_d.last          = 1'b1;
        word_sent_d           = 1'b0;
        pop_o                 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    token_q <= token_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      word_sent_q <= 1'b0;
    end else begin
      word_sent_q <= word_sent_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  `EFL_ASSERT(a_word_sent_head, word_sent_q |-> (!empty_i && head_i.emit_word && head_i.emit_op))
  `EFL_ASSERT(a_pop_nonempty, pop_o |-> !empty_i)
  `EFL_ASSERT(a_pair_word_first, (pop_o && head_i.emit_word && head_i.emit_op) |-> word_sent_q)
  `EFL_ASSERT(a_pair_word_not_last, (load && word_sent_d) |=> (valid_q && !token_q.last))

endmodule

// ===== hdl/exchange_file_lexer_core.sv =====
// Exchange file lexer top level: front end, action queue and token back end.
// Depends on efl_pkg, efl_if, efl_front, efl_queue and efl_back.
//
// Usage:
//   byte_i carries one file byte per word (data_byte, stream_end); stream_end
//   flushes a pending word and restarts the byte counter at zero.
//   token_o carries tokens: token_kind, operator_byte, start_offset and last,
//   where last marks the final token caused by one input word.
// Path: a token reaches token_o through the action queue and the output register.
// Throughput: one byte per cycle while the queue is not full; the back end issues
//   one token per cycle while token_o is ready, so a delimiter that closes a word
//   yields two tokens from one byte; the QUEUE_DEPTH action queue absorbs the difference.
// Stall: when token_o is not ready the output register holds, the queue
//   fills, and byte_i.ready drops once the queue is full.
// Reset: rst_ni clears counter, word state, queue and the output valid.
module exchange_file_lexer_core #(
  parameter int unsigned OFFSET_BITS = efl_pkg::OFFSET_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = efl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  efl_byte_if.sink     byte_i,
  efl_token_if.source  token_o
);

  efl_pkg::action_t action, head;
  efl_pkg::token_t  token;
  logic             push, pop, empty, full;

  efl_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (byte_i.valid),
    .ready_o      (byte_i.ready),
    .data_byte_i  (byte_i.data_byte),
    .stream_end_i (byte_i.stream_end),
    .full_i       (full),
    .push_o       (push),
    .action_o     (action)
  );

  efl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .action_i (action),
    .pop_i    (pop),
    .head_o   (head),
    .empty_o  (empty),
    .full_o   (full)
  );

  efl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .valid_o (token_o.valid),
    .ready_i (token_o.ready),
    .token_o (token)
  );

  assign token_o.token_kind    = token.token_kind;
  assign token_o.operator_byte = token.operator_byte;
  assign token_o.start_offset  = token.start_offset;
  assign token_o.last          = token.last;

endmodule

// ===== bench/tb_exchange_file_lexer_core.sv =====
// Self-checking bench for exchange_file_lexer_core: directed and random byte streams in,
// tokens out, checked against an in-bench tokenizer model. Needs efl_pkg, efl_if and the RTL.
module tb_exchange_file_lexer_core;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned TARGET_WORDS = 2000;
  localparam int unsigned QUIET_WORDS  = 250;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       drain;
  } byte_word_t;

  logic clk_i;
  logic rst_ni;

  efl_byte_if  byte_if ();
  efl_token_if token_if ();

  exchange_file_lexer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .token_o(token_if)
  );

  byte_word_t       pending_words[$];
  efl_pkg::token_t  expected_tokens[$];

  logic [31:0] lex_pos;
  logic        lex_in_word;
  logic [31:0] lex_word_start;
  logic        lex_in_string;
  logic        lex_in_comment;
  logic [7:0]  lex_prev;

  logic        byte_fire;
  int unsigned send_gap;
  int unsigned ready_stall;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned words_queued;
  int unsigned bytes_taken;
  int unsigned word_tokens;
  int unsigned op_tokens;
  int unsigned flushes;

  function automatic logic is_blank(input logic [7:0] c);
    return c == efl_pkg::CH_SPACE || c == efl_pkg::CH_CR ||
           c == efl_pkg::CH_LF || c == efl_pkg::CH_TAB;
  endfunction

  function automatic logic is_delimiter(input logic [7:0] c);
    return c == efl_pkg::CH_LPAREN || c == efl_pkg::CH_RPAREN || c == efl_pkg::CH_EQUAL ||
           c == efl_pkg::CH_COMMA || c == efl_pkg::CH_SEMI;
  endfunction

  function automatic logic is_single_op(input logic [7:0] c);
    return is_delimiter(c) || c == efl_pkg::CH_DOLLAR || c == efl_pkg::CH_STAR;
  endfunction

  task automatic expect_token(input logic kind, input logic [7:0] op,
                              input logic [31:0] start, input logic is_last);
    efl_pkg::token_t tok;
    tok.token_kind    = kind;
    tok.operator_byte = op;
    tok.start_offset  = start;
    tok.last          = is_last;
    expected_tokens   = {expected_tokens, tok};
  endtask

  task automatic add_pending(input logic [7:0] b, input logic fin_w, input logic drain_w);
    byte_word_t w;
    w.data        = b;
    w.fin         = fin_w;
    w.drain       = drain_w;
    pending_words = {pending_words, w};
  endtask

  task automatic clear_word_state();
    lex_in_word    = 1'b0;
    lex_word_start = '0;
    lex_in_string  = 1'b0;
    lex_in_comment = 1'b0;
    lex_prev       = 8'h00;
  endtask

  task automatic track_word_byte(input logic [7:0] c);
    if (lex_in_comment && lex_prev == efl_pkg::CH_STAR && c == efl_pkg::CH_SLASH) begin
      lex_in_comment = 1'b0;
    end else if (!lex_in_string && !lex_in_comment && lex_prev == efl_pkg::CH_SLASH &&
                 c == efl_pkg::CH_STAR) begin
      lex_in_comment = 1'b1;
    end else if (!lex_in_comment && c == efl_pkg::CH_QUOTE) begin
      lex_in_string = !lex_in_string;
    end
    lex_prev = c;
  endtask

  task automatic predict_tokens(input logic [7:0] c, input logic fin);
    logic [31:0] here;
    here = lex_pos;
    if (fin) begin
      if (lex_in_word) begin
        expect_token(efl_pkg::KIND_WORD, 8'h00, lex_word_start, 1'b1);
      end
      lex_pos = '0;
      clear_word_state();
    end else begin
      lex_pos = here + 32'd1;
      if (!lex_in_word) begin
        if (!is_blank(c)) begin
          if (is_single_op(c)) begin
            expect_token(efl_pkg::KIND_OPERATOR, c, here, 1'b1);
          end else begin
            clear_word_state();
            lex_in_word    = 1'b1;
            lex_word_start = here;
            track_word_byte(c);
          end
        end
      end else if ((!lex_in_string || lex_in_comment) && is_delimiter(c)) begin
        expect_token(efl_pkg::KIND_WORD, 8'h00, lex_word_start, 1'b0);
        expect_token(efl_pkg::KIND_OPERATOR, c, here, 1'b1);
        clear_word_state();
      end else if (lex_in_comment || lex_in_string || !is_blank(c)) begin
        track_word_byte(c);
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    add_pending(b, 1'b0, 1'b0);
    words_queued++;
  endtask

  task automatic push_end();
    add_pending(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    words_queued++;
  endtask

  task automatic push_drain();
    add_pending(8'h00, 1'b0, 1'b1);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endtask

  task automatic maybe_blank();
    case ($urandom_range(0, 7))
      0: push_byte(efl_pkg::CH_SPACE);
      1: push_byte(efl_pkg::CH_TAB);
      2: push_byte(efl_pkg::CH_CR);
      3: push_byte(efl_pkg::CH_LF);
      default: ;
    endcase
  endtask

  task automatic gen_string_literal();
    string charset;
    charset = "abXZ09_ ,;()=*/$.-\t\n'";
    push_byte(efl_pkg::CH_QUOTE);
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 15) == 0) begin
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        push_byte(charset[$urandom_range(0, charset.len() - 1)]);
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      push_byte(efl_pkg::CH_QUOTE);
    end
  endtask

  task automatic gen_comment();
    string charset;
    charset = "ab ,;()=*'/$";
    push_text("/*");
    repeat ($urandom_range(0, 6)) begin
      push_byte(charset[$urandom_range(0, charset.len() - 1)]);
    end
    if ($urandom_range(0, 7) != 0) begin
      push_text("*/");
    end
  endtask

  task automatic gen_value();
    case ($urandom_range(0, 7))
      0: push_byte(efl_pkg::CH_DOLLAR);
      1: push_byte(efl_pkg::CH_STAR);
      2: push_text($sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99)));
      3: gen_string_literal();
      4: push_text($sformatf("#%0d", $urandom_range(1, 9999)));
      5: push_text($urandom_range(0, 1) ? ".T." : ".UNKNOWN.");
      6: begin
        gen_comment();
        push_text($sformatf("%0d", $urandom_range(0, 99)));
      end
      default: push_text($sformatf("-%0dE%0d", $urandom_range(1, 9), $urandom_range(0, 9)));
    endcase
  endtask

  task automatic gen_record();
    int n_args;
    push_text($sformatf("#%0d", $urandom_range(1, 9999)));
    maybe_blank();
    push_byte(efl_pkg::CH_EQUAL);
    maybe_blank();
    push_text($urandom_range(0, 1) ? "IFCWALL" : "CARTESIAN_POINT");
    push_byte(efl_pkg::CH_LPAREN);
    n_args = $urandom_range(0, 5);
    for (int i = 0; i < n_args; i++) begin
      if (i != 0) begin
        push_byte(efl_pkg::CH_COMMA);
      end
      maybe_blank();
      if ($urandom_range(0, 4) == 0) begin
        push_byte(efl_pkg::CH_LPAREN);
        repeat ($urandom_range(1, 3)) begin
          gen_value();
          push_byte(efl_pkg::CH_COMMA);
        end
        gen_value();
        push_byte(efl_pkg::CH_RPAREN);
      end else begin
        gen_value();
      end
      maybe_blank();
    end
    push_byte(efl_pkg::CH_RPAREN);
    push_byte(efl_pkg::CH_SEMI);
    maybe_blank();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    int unsigned next_drain;
    rst_ni               = 1'b0;
    byte_if.valid        = 1'b0;
    byte_if.data_byte    = 8'h00;
    byte_if.stream_end   = 1'b0;
    token_if.ready       = 1'b0;
    byte_fire            = 1'b0;
    send_gap             = 0;
    ready_stall          = 0;
    fail_count           = 0;
    words_queued         = 0;
    bytes_taken          = 0;
    word_tokens          = 0;
    op_tokens            = 0;
    flushes              = 0;
    lex_pos              = '0;
    clear_word_state();

    push_text("()=,;$*");
    push_byte(efl_pkg::CH_SPACE);
    push_byte(efl_pkg::CH_TAB);
    push_byte(efl_pkg::CH_CR);
    push_byte(efl_pkg::CH_LF);
    push_end();
    push_text("A$'(';");
    push_text("/**/*,");
    push_byte(8'hFF);
    push_end();
    push_drain();

    next_drain = 500;
    while (words_queued < TARGET_WORDS) begin
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        gen_record();
      end else if (pick < 86) begin
        repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
      end else if (pick < 94) begin
        push_end();
      end else begin
        gen_comment();
      end
      if (words_queued >= next_drain) begin
        push_drain();
        next_drain += 500;
      end
    end
    push_end();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_words.size() != 0 || expected_tokens.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (expected_tokens.size() != 0) begin
      $error("%0d predicted tokens never arrived", expected_tokens.size());
      fail_count++;
    end
    $display("Run covered %0d accepted words, %0d of them stream ends.", bytes_taken, flushes);
    $display("Checked %0d word tokens and %0d operator tokens.", word_tokens, op_tokens);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    efl_pkg::token_t tok;
    if (!rst_ni) begin
      byte_fire = 1'b0;
    end else begin
      byte_fire = byte_if.valid && byte_if.ready;
      if (byte_fire) begin
        bytes_taken++;
        if (byte_if.stream_end) begin
          flushes++;
        end
        predict_tokens(byte_if.data_byte, byte_if.stream_end);
      end
      if (token_if.valid && token_if.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("token with no prediction: kind %0d, operator %0h, offset %0d, last %0d",
                 token_if.token_kind, token_if.operator_byte, token_if.start_offset,
                 token_if.last);
          fail_count++;
        end else begin
          tok = expected_tokens.pop_front();
          if (tok.token_kind == efl_pkg::KIND_WORD) begin
            word_tokens++;
          end else begin
            op_tokens++;
          end
          if (token_if.token_kind !== tok.token_kind) begin
            $error("token_kind: expected %0d, got %0d", tok.token_kind, token_if.token_kind);
            fail_count++;
          end
          if (token_if.operator_byte !== tok.operator_byte) begin
            $error("operator_byte: expected %0h, got %0h", tok.operator_byte,
                   token_if.operator_byte);
            fail_count++;
          end
          if (token_if.start_offset !== tok.start_offset) begin
            $error("start_offset: expected %0d, got %0d", tok.start_offset,
                   token_if.start_offset);
            fail_count++;
          end
          if (token_if.last !== tok.last) begin
            $error("last: expected %0d, got %0d", tok.last, token_if.last);
            fail_count++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    logic holding;
    logic quiet;
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
    end else begin
      if (byte_fire) begin
        pending_words.delete(0);
      end
      holding = byte_if.valid && !byte_fire;
      quiet   = pending_words.size() < QUIET_WORDS;
      if (!holding) begin
        if (send_gap != 0) begin
          send_gap--;
          byte_if.valid <= 1'b0;
        end else if (pending_words.size() == 0) begin
          byte_if.valid <= 1'b0;
        end else if (pending_words[0].drain) begin
          byte_if.valid <= 1'b0;
          if (expected_tokens.size() == 0) begin
            pending_words.delete(0);
          end
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 13);
          byte_if.valid <= 1'b0;
        end else begin
          byte_if.valid      <= 1'b1;
          byte_if.data_byte  <= pending_words[0].data;
          byte_if.stream_end <= pending_words[0].fin;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      token_if.ready <= 1'b0;
    end else if (ready_stall != 0) begin
      ready_stall--;
      token_if.ready <= 1'b0;
    end else if (pending_words.size() >= QUIET_WORDS && $urandom_range(0, 9) == 0) begin
      ready_stall = $urandom_range(0, 13);
      token_if.ready <= 1'b0;
    end else begin
      token_if.ready <= 1'b1;
    end
  end

endmodule
